// File: sv/ule_pkg.sv
// ----------------------------------------------------------------------------
// ule_pkg
// Shared types, character codes and bit timing helpers for the line echo unit.
// ----------------------------------------------------------------------------
package ule_pkg;

  localparam int unsigned TICK_W = 16;

  localparam logic [TICK_W-1:0] BIT_TICKS_RESET = 16'd417;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_ZERO = 8'h00;

  localparam logic [2:0] RX_LAST_BIT  = 3'd7;
  localparam logic [3:0] TX_START_BIT = 4'd0;
  localparam logic [3:0] TX_LAST_DATA = 4'd8;
  localparam logic [3:0] TX_STOP_BIT  = 4'd9;

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_START,
    RX_DATA,
    RX_STOP
  } rx_phase_e;

  typedef enum logic [1:0] {
    TX_IDLE,
    TX_TEXT,
    TX_LF,
    TX_BS
  } tx_phase_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] value;
  } rx_byte_t;

  function automatic logic [TICK_W-1:0] full_bit(input logic [TICK_W-1:0] bt);
    return (bt == '0) ? TICK_W'(1) : bt;
  endfunction

  function automatic logic [TICK_W-1:0] half_bit(input logic [TICK_W-1:0] bt);
    logic [TICK_W-1:0] h;
    h = {1'b0, bt[TICK_W-1:1]};
    return (h == '0) ? TICK_W'(1) : h;
  endfunction

endpackage

// File: sv/uart_line_echo_unit.sv
// ----------------------------------------------------------------------------
// uart_line_echo_unit
// Tick-driven 8N1 receiver that collects a line and echoes it back on TX.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o   | rx_level_i
//  out     | out_valid_o / out_ready_i | tx_level_o byte_valid_o byte_value_o
//          |                           | echo_busy_o
//  cfg     | cfg_valid_i / cfg_ready_o | bit_ticks_i
//
//  One item per clock while out is not stalled: an item is held in the input
//  register, and its receiver/transmitter step runs from there into the
//  output register. The pipeline only advances when the output register is
//  empty or being drained, so stalls on out hold both stages. Reset clears
//  all control state and sets bit_ticks to 417; the line memory needs no
//  clearing pass, a fill count bounds reads.
// ----------------------------------------------------------------------------
module uart_line_echo_unit import ule_pkg::*; #(
  parameter int unsigned LINE_CHARS = 80
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              rx_level_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              tx_level_o,
  output logic              byte_valid_o,
  output logic [7:0]        byte_value_o,
  output logic              echo_busy_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TICK_W-1:0] bit_ticks_i
);

  localparam int unsigned CW = $clog2(LINE_CHARS + 1);
  localparam int unsigned AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

  logic [TICK_W-1:0] bit_ticks_q;
  logic              in_valid_q;
  logic              level_q;
  logic              out_valid_q;
  logic              tx_level_q;
  logic              byte_valid_q;
  logic [7:0]        byte_value_q;
  logic              echo_busy_q;

  logic              advance;
  logic [TICK_W-1:0] full_ticks;
  logic [TICK_W-1:0] half_ticks;
  rx_byte_t          rx_byte;
  logic              line_end;
  logic [CW-1:0]     echo_count;
  logic [7:0]        first_char;
  logic [7:0]        rd_data;
  logic [AW-1:0]     rd_addr;
  logic              busy;
  logic              tx_bit;
  logic              echo_done;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign full_ticks  = full_bit(bit_ticks_q);
  assign half_ticks  = half_bit(bit_ticks_q);

  ule_rx u_rx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance && !busy),
    .level_i    (level_q),
    .full_bit_i (full_ticks),
    .half_bit_i (half_ticks),
    .line_end_i (line_end),
    .byte_o     (rx_byte)
  );

  ule_line_store #(.LINE_CHARS(LINE_CHARS)) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (rx_byte),
    .clear_i      (echo_done),
    .rd_addr_i    (rd_addr),
    .rd_data_o    (rd_data),
    .line_end_o   (line_end),
    .echo_count_o (echo_count),
    .first_char_o (first_char)
  );

  ule_tx #(.LINE_CHARS(LINE_CHARS)) u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .start_i      (line_end),
    .echo_count_i (echo_count),
    .first_char_i (first_char),
    .rd_data_i    (rd_data),
    .full_bit_i   (full_ticks),
    .rd_addr_o    (rd_addr),
    .busy_o       (busy),
    .tx_bit_o     (tx_bit),
    .done_o       (echo_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q <= BIT_TICKS_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        bit_ticks_q <= bit_ticks_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      level_q <= rx_level_i;
    end
    if (advance) begin
      tx_level_q   <= tx_bit;
      byte_valid_q <= rx_byte.valid;
      byte_value_q <= rx_byte.value;
      echo_busy_q  <= busy;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_level_o   = tx_level_q;
  assign byte_valid_o = byte_valid_q;
  assign byte_value_o = byte_value_q;
  assign echo_busy_o  = echo_busy_q;

endmodule

// File: sv/ule_rx.sv
// ----------------------------------------------------------------------------
// ule_rx
// Serial receiver: start detect, half-bit recheck, eight data bits LSB first.
// ----------------------------------------------------------------------------
module ule_rx import ule_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              level_i,
  input  logic [TICK_W-1:0] full_bit_i,
  input  logic [TICK_W-1:0] half_bit_i,
  input  logic              line_end_i,
  output rx_byte_t          byte_o
);

  rx_phase_e         phase_q, phase_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [2:0]        bit_q, bit_d;
  logic [7:0]        shift_q, shift_d;

  logic [TICK_W-1:0] tick_inc;
  logic [7:0]        shift_nxt;
  logic              bit_done;

  assign tick_inc  = tick_q + TICK_W'(1);
  assign shift_nxt = {level_i, shift_q[7:1]};
  assign bit_done  = (tick_inc >= full_bit_i);

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    if (en_i) begin
      unique case (phase_q)
        RX_IDLE: begin
          if (!level_i) begin
            phase_d = RX_START;
            tick_d  = '0;
          end
        end
        RX_START: begin
          if (tick_inc >= half_bit_i) begin
            tick_d = '0;
            if (level_i) begin
              phase_d = RX_IDLE;
            end else begin
              phase_d = RX_DATA;
              bit_d   = '0;
              shift_d = '0;
            end
          end else begin
            tick_d = tick_inc;
          end
        end
        RX_DATA: begin
          if (bit_done) begin
            tick_d  = '0;
            shift_d = shift_nxt;
            bit_d   = bit_q + 3'd1;
            if (bit_q == RX_LAST_BIT) begin
              phase_d = line_end_i ? RX_IDLE : RX_STOP;
            end
          end else begin
            tick_d = tick_inc;
          end
        end
        RX_STOP: begin
          if (bit_done) begin
            tick_d  = '0;
            phase_d = RX_IDLE;
          end else begin
            tick_d = tick_inc;
          end
        end
        default: phase_d = RX_IDLE;
      endcase
    end
  end

  always_comb begin
    byte_o.valid = en_i && (phase_q == RX_DATA) && bit_done && (bit_q == RX_LAST_BIT);
    byte_o.value = byte_o.valid ? shift_nxt : CH_ZERO;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= RX_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
    end
  end

endmodule

// File: sv/ule_line_store.sv
// ----------------------------------------------------------------------------
// ule_line_store
// Line memory with fill count, echo length tracking and a registered read port.
// ----------------------------------------------------------------------------
module ule_line_store import ule_pkg::*; #(
  parameter int unsigned LINE_CHARS = 80
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rx_byte_t                             byte_i,
  input  logic                                 clear_i,
  input  logic [(LINE_CHARS > 1 ? $clog2(LINE_CHARS) : 1)-1:0] rd_addr_i,
  output logic [7:0]                           rd_data_o,
  output logic                                 line_end_o,
  output logic [$clog2(LINE_CHARS+1)-1:0]      echo_count_o,
  output logic [7:0]                           first_char_o
);

  localparam int unsigned CW = $clog2(LINE_CHARS + 1);
  localparam int unsigned AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam logic [CW:0] LINE_MAX = (CW + 1)'(LINE_CHARS);

  logic [7:0]    mem [LINE_CHARS];
  logic [7:0]    rd_q;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] echo_q, echo_d;
  logic          zero_q, zero_d;
  logic [7:0]    first_q, first_d;

  logic          is_cr;
  logic          take;
  logic          wr_en;
  logic [CW:0]   len_inc;

  assign is_cr   = (byte_i.value == CH_CR);
  assign take    = byte_i.valid && !is_cr;
  assign len_inc = {1'b0, len_q} + (CW + 1)'(1);
  assign wr_en   = take && ({1'b0, len_q} < LINE_MAX);

  always_comb begin
    len_d   = len_q;
    echo_d  = echo_q;
    zero_d  = zero_q;
    first_d = first_q;
    if (clear_i) begin
      len_d  = '0;
      echo_d = '0;
      zero_d = 1'b0;
    end else if (take) begin
      len_d = len_inc[CW-1:0];
      if (byte_i.value == CH_ZERO) begin
        zero_d = 1'b1;
      end else if (!zero_q) begin
        echo_d = echo_q + CW'(1);
      end
      if (len_q == '0) begin
        first_d = byte_i.value;
      end
    end
  end

  assign line_end_o   = byte_i.valid && (is_cr || (len_inc >= LINE_MAX));
  assign echo_count_o = take ? echo_d : echo_q;
  assign first_char_o = take ? first_d : first_q;
  assign rd_data_o    = rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[len_q[AW-1:0]] <= byte_i.value;
    end
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      echo_q  <= '0;
      zero_q  <= 1'b0;
      first_q <= '0;
    end else begin
      len_q   <= len_d;
      echo_q  <= echo_d;
      zero_q  <= zero_d;
      first_q <= first_d;
    end
  end

endmodule

// File: sv/ule_tx.sv
// ----------------------------------------------------------------------------
// ule_tx
// 8N1 transmitter sequencing the echo: text, line feed, then backspaces.
// ----------------------------------------------------------------------------
module ule_tx import ule_pkg::*; #(
  parameter int unsigned LINE_CHARS = 80
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 start_i,
  input  logic [$clog2(LINE_CHARS+1)-1:0]      echo_count_i,
  input  logic [7:0]                           first_char_i,
  input  logic [7:0]                           rd_data_i,
  input  logic [TICK_W-1:0]                    full_bit_i,
  output logic [(LINE_CHARS > 1 ? $clog2(LINE_CHARS) : 1)-1:0] rd_addr_o,
  output logic                                 busy_o,
  output logic                                 tx_bit_o,
  output logic                                 done_o
);

  localparam int unsigned CW = $clog2(LINE_CHARS + 1);
  localparam logic [CW:0] LINE_MAX = (CW + 1)'(LINE_CHARS);

  tx_phase_e         phase_q, phase_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [3:0]        bit_q, bit_d;
  logic [7:0]        shift_q, shift_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     echo_q, echo_d;

  logic [TICK_W-1:0] tick_inc;
  logic [CW:0]       idx_inc;
  logic [CW:0]       echo_ext;
  logic [2:0]        data_sel;

  assign tick_inc = tick_q + TICK_W'(1);
  assign idx_inc  = {1'b0, idx_q} + (CW + 1)'(1);
  assign echo_ext = {1'b0, echo_q};
  assign data_sel = 3'(bit_q - 4'd1);

  assign rd_addr_o = (idx_inc < LINE_MAX) ? idx_inc[$bits(rd_addr_o)-1:0] : '0;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    idx_d   = idx_q;
    echo_d  = echo_q;
    done_o  = 1'b0;
    if (en_i) begin
      if (phase_q != TX_IDLE) begin
        if (tick_inc >= full_bit_i) begin
          tick_d = '0;
          bit_d  = bit_q + 4'd1;
          if (bit_q == TX_STOP_BIT) begin
            bit_d = TX_START_BIT;
            unique case (phase_q)
              TX_TEXT: begin
                if ((idx_inc >= echo_ext) || (idx_inc >= LINE_MAX)) begin
                  idx_d   = '0;
                  phase_d = TX_LF;
                  shift_d = CH_LF;
                end else begin
                  idx_d   = idx_inc[CW-1:0];
                  shift_d = rd_data_i;
                end
              end
              TX_LF: begin
                if (echo_q == '0) begin
                  done_o = 1'b1;
                end else begin
                  idx_d   = '0;
                  phase_d = TX_BS;
                  shift_d = CH_BS;
                end
              end
              TX_BS: begin
                if (idx_inc >= echo_ext) begin
                  done_o = 1'b1;
                end else begin
                  idx_d   = idx_inc[CW-1:0];
                  shift_d = CH_BS;
                end
              end
              default: phase_d = TX_IDLE;
            endcase
            if (done_o) begin
              phase_d = TX_IDLE;
              idx_d   = '0;
              shift_d = '0;
              echo_d  = '0;
            end
          end
        end else begin
          tick_d = tick_inc;
        end
      end else if (start_i) begin
        echo_d = echo_count_i;
        idx_d  = '0;
        bit_d  = TX_START_BIT;
        tick_d = '0;
        if (echo_count_i != '0) begin
          phase_d = TX_TEXT;
          shift_d = first_char_i;
        end else begin
          phase_d = TX_LF;
          shift_d = CH_LF;
        end
      end
    end
  end

  always_comb begin
    busy_o = (phase_q != TX_IDLE);
    priority if (!busy_o) begin
      tx_bit_o = 1'b1;
    end else if (bit_q == TX_START_BIT) begin
      tx_bit_o = 1'b0;
    end else if (bit_q <= TX_LAST_DATA) begin
      tx_bit_o = shift_q[data_sel];
    end else begin
      tx_bit_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= TX_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      idx_q   <= '0;
      echo_q  <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      idx_q   <= idx_d;
      echo_q  <= echo_d;
    end
  end

endmodule

// File: sv/ule_checker.sv
// ----------------------------------------------------------------------------
// ule_checker
// Port-level checks on the line echo unit's result items.
// ----------------------------------------------------------------------------
module ule_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       tx_level_o,
  input logic       byte_valid_o,
  input logic [7:0] byte_value_o,
  input logic       echo_busy_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_level_o)
      && $stable(byte_valid_o) && $stable(byte_value_o) && $stable(echo_busy_o))
    else $error("out item changed while stalled");

  a_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !echo_busy_o |-> tx_level_o)
    else $error("tx not high while echo idle");

  a_no_rx_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> !echo_busy_o)
    else $error("byte received during echo");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> byte_value_o == 8'h00)
    else $error("byte value set without byte valid");

endmodule

bind uart_line_echo_unit ule_checker u_ule_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .tx_level_o   (tx_level_o),
  .byte_valid_o (byte_valid_o),
  .byte_value_o (byte_value_o),
  .echo_busy_o  (echo_busy_o)
);

// File: tb/uart_line_echo_unit_checker.sv
// ----------------------------------------------------------------------------
// uart_line_echo_unit_checker
// Watches the tick, result and bit time channels of the line echo unit. Each
// accepted tick is run through a cycle model of the 8N1 receiver, line store
// and echo transmitter. The resulting pin values are queued and compared,
// field by field, with the results the unit hands out.
// ----------------------------------------------------------------------------
module uart_line_echo_unit_checker import ule_pkg::*; #(
  parameter int unsigned LINE_CHARS = 80
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_o,
  input  logic              rx_level_i,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              tx_level_o,
  input  logic              byte_valid_o,
  input  logic [7:0]        byte_value_o,
  input  logic              echo_busy_o,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_o,
  input  logic [TICK_W-1:0] bit_ticks_i,
  output int                fail_count_o,
  output int                results_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       tx_level;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       echo_busy;
  } pin_tick_t;

  logic [TICK_W-1:0] bit_ticks;
  rx_phase_e         rx_ph;
  logic [TICK_W-1:0] rx_cnt;
  logic [3:0]        rx_bits;
  logic [7:0]        rx_sh;
  logic [7:0]        line_mem [LINE_CHARS];
  logic [6:0]        line_len;
  tx_phase_e         tx_ph;
  logic [TICK_W-1:0] tx_cnt;
  logic [3:0]        tx_bit;
  logic [7:0]        tx_sh;
  logic [6:0]        tx_char;
  logic [6:0]        echo_n;
  pin_tick_t         owed_ticks [$];

  function automatic void load_char(input tx_phase_e ph, input logic [7:0] ch);
    tx_ph  = ph;
    tx_sh  = ch;
    tx_bit = '0;
    tx_cnt = '0;
  endfunction

  function automatic void clear_line();
    foreach (line_mem[i]) line_mem[i] = '0;
    line_len = '0;
    tx_ph    = TX_IDLE;
    tx_char  = '0;
    tx_bit   = '0;
    tx_cnt   = '0;
    tx_sh    = '0;
    echo_n   = '0;
  endfunction

  function automatic pin_tick_t step_line_echo(input logic lvl);
    pin_tick_t         t;
    logic [TICK_W-1:0] span;
    logic [TICK_W-1:0] half_span;
    logic              line_done;
    span      = (bit_ticks == '0) ? TICK_W'(1) : bit_ticks;
    half_span = bit_ticks >> 1;
    if (half_span == '0) half_span = TICK_W'(1);
    t.tx_level   = 1'b1;
    t.byte_valid = 1'b0;
    t.byte_value = '0;
    t.echo_busy  = (tx_ph != TX_IDLE);
    if (t.echo_busy) begin
      if (tx_bit == TX_START_BIT) t.tx_level = 1'b0;
      else if (tx_bit <= TX_LAST_DATA) t.tx_level = tx_sh[tx_bit - 4'd1];
      tx_cnt++;
      if (tx_cnt >= span) begin
        tx_cnt = '0;
        tx_bit++;
        if (tx_bit > TX_STOP_BIT) begin
          case (tx_ph)
            TX_TEXT: begin
              tx_char++;
              if (tx_char >= echo_n || tx_char >= LINE_CHARS) begin
                tx_char = '0;
                load_char(TX_LF, CH_LF);
              end else begin
                load_char(TX_TEXT, line_mem[tx_char]);
              end
            end
            TX_LF: begin
              if (echo_n == '0) begin
                clear_line();
              end else begin
                tx_char = '0;
                load_char(TX_BS, CH_BS);
              end
            end
            default: begin
              tx_char++;
              if (tx_char >= echo_n) clear_line();
              else load_char(TX_BS, CH_BS);
            end
          endcase
        end
      end
    end else begin
      case (rx_ph)
        RX_IDLE: begin
          if (!lvl) begin
            rx_ph  = RX_START;
            rx_cnt = '0;
          end
        end
        RX_START: begin
          rx_cnt++;
          if (rx_cnt >= half_span) begin
            rx_cnt = '0;
            if (lvl) begin
              rx_ph = RX_IDLE;
            end else begin
              rx_ph   = RX_DATA;
              rx_bits = '0;
              rx_sh   = '0;
            end
          end
        end
        RX_DATA: begin
          rx_cnt++;
          if (rx_cnt >= span) begin
            rx_cnt = '0;
            rx_sh  = {lvl, rx_sh[7:1]};
            rx_bits++;
            if (rx_bits > {1'b0, RX_LAST_BIT}) begin
              rx_bits      = '0;
              t.byte_valid = 1'b1;
              t.byte_value = rx_sh;
              rx_ph        = RX_STOP;
              line_done    = (rx_sh == CH_CR);
              if (!line_done) begin
                if (line_len < LINE_CHARS) line_mem[line_len] = rx_sh;
                line_len++;
                line_done = (line_len >= LINE_CHARS);
              end
              if (line_done) begin
                rx_ph  = RX_IDLE;
                echo_n = '0;
                while (echo_n < line_len && echo_n < LINE_CHARS &&
                       line_mem[echo_n] != CH_ZERO) echo_n++;
                tx_char = '0;
                if (echo_n != '0) load_char(TX_TEXT, line_mem[0]);
                else load_char(TX_LF, CH_LF);
              end
            end
          end
        end
        default: begin
          rx_cnt++;
          if (rx_cnt >= span) begin
            rx_cnt = '0;
            rx_ph  = RX_IDLE;
          end
        end
      endcase
    end
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pin_tick_t want;
    if (!rst_ni) begin
      bit_ticks = BIT_TICKS_RESET;
      rx_ph     = RX_IDLE;
      rx_cnt    = '0;
      rx_bits   = '0;
      rx_sh     = '0;
      clear_line();
      owed_ticks.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) bit_ticks = bit_ticks_i;
      if (out_valid_o && out_ready_i) begin
        if (owed_ticks.size() == 0) begin
          $error("result item arrived with no tick outstanding");
          fail_count_o++;
        end else begin
          want = owed_ticks.pop_front();
          if (tx_level_o !== want.tx_level) begin
            $error("tx_level expected %0h got %0h", want.tx_level, tx_level_o);
            fail_count_o++;
          end
          if (byte_valid_o !== want.byte_valid) begin
            $error("byte_valid expected %0h got %0h", want.byte_valid, byte_valid_o);
            fail_count_o++;
          end
          if (byte_value_o !== want.byte_value) begin
            $error("byte_value expected %0h got %0h", want.byte_value, byte_value_o);
            fail_count_o++;
          end
          if (echo_busy_o !== want.echo_busy) begin
            $error("echo_busy expected %0h got %0h", want.echo_busy, echo_busy_o);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_o) owed_ticks.push_back(step_line_echo(rx_level_i));
    end
    results_owed_o = owed_ticks.size();
  end

endmodule

// File: tb/uart_line_echo_unit_tb.sv
// ----------------------------------------------------------------------------
// uart_line_echo_unit_tb
// Drives the line echo unit one RX tick per item: serial frames built for the
// current bit time, false starts, noise and idle ticks long enough to cover
// each echo. Opens with short directed lines and bit time extremes, then runs
// random traffic under several idle and stall mixes. A separate checker
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module uart_line_echo_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ule_pkg::*;

  localparam int unsigned LINE_CHARS  = 80;
  localparam int          STALL_LIMIT = 2000;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic              rx_level_i   = 1'b1;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic              tx_level_o;
  logic              byte_valid_o;
  logic [7:0]        byte_value_o;
  logic              echo_busy_o;
  logic              cfg_valid_i  = 1'b0;
  logic              cfg_ready_o;
  logic [TICK_W-1:0] bit_ticks_i  = '0;

  int fail_count;
  int results_owed;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int tick_full      = 417;
  int tick_half      = 208;
  int start_len      = 417;
  int items_sent     = 0;
  int line_fill      = 0;
  int line_text      = 0;
  logic text_cut     = 1'b0;
  int quiet_cycles   = 0;

  uart_line_echo_unit #(.LINE_CHARS(LINE_CHARS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_level_i  (rx_level_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_level_o  (tx_level_o),
    .byte_valid_o(byte_valid_o),
    .byte_value_o(byte_value_o),
    .echo_busy_o (echo_busy_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .bit_ticks_i (bit_ticks_i)
  );

  uart_line_echo_unit_checker #(.LINE_CHARS(LINE_CHARS)) echo_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_level_i    (rx_level_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tx_level_o    (tx_level_o),
    .byte_valid_o  (byte_valid_o),
    .byte_value_o  (byte_value_o),
    .echo_busy_o   (echo_busy_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .bit_ticks_i   (bit_ticks_i),
    .fail_count_o  (fail_count),
    .results_owed_o(results_owed)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("uart_line_echo_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_level(input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_level_i <= lvl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (results_owed != 0) @(negedge clk_i);
  endtask

  task automatic write_bit_ticks(input logic [TICK_W-1:0] v);
    drain_results();
    cfg_valid_i <= 1'b1;
    bit_ticks_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    tick_full = (v == '0) ? 1 : int'(v);
    tick_half = ((v >> 1) == '0) ? 1 : int'(v >> 1);
    start_len = (tick_half < tick_full) ? tick_full : tick_half + 1;
  endtask

  // start bit stretched so that every data sample lands inside its bit
  task automatic send_byte(input logic [7:0] b);
    repeat (start_len) send_level(1'b0);
    for (int i = 0; i < 8; i++) repeat (tick_full) send_level(b[i]);
    repeat (tick_full + $urandom_range(2)) send_level(1'b1);
    if (b != CH_CR) begin
      line_fill++;
      if (b == CH_ZERO) text_cut = 1'b1;
      else if (!text_cut) line_text++;
    end
    if (b == CH_CR || line_fill == LINE_CHARS) begin
      repeat (10 * tick_full) send_level(1'($urandom_range(1)));
      repeat ((20 * line_text + 2) * tick_full + 2) send_level(1'b1);
      line_fill = 0;
      line_text = 0;
      text_cut  = 1'b0;
    end
  endtask

  initial begin
    logic [7:0] opening [7];
    logic [7:0] ch;
    int         lap_start;
    int         pick;
    int         low_len;

    opening = '{8'h41, CH_ZERO, 8'h7E, CH_CR, CH_CR, 8'hA5, CH_CR};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    repeat (4) send_level(1'b1);
    // change the bit time while a start bit is being timed
    write_bit_ticks('1);
    repeat (10) send_level(1'b0);
    write_bit_ticks(TICK_W'(2));
    repeat (3) send_level(1'b1);

    foreach (opening[i]) send_byte(opening[i]);
    send_level(1'b0);
    repeat (3) send_level(1'b1);

    write_bit_ticks('0);
    send_byte(8'h30);
    send_byte(CH_CR);

    for (int lap = 0; lap < 4; lap++) begin
      write_bit_ticks(TICK_W'($urandom_range(3)));
      send_idle_pct  = (lap == 1) ? 47 : (lap == 3) ? 13 : 0;
      recv_stall_pct = (lap == 2) ? 47 : (lap == 3) ? 13 : 0;
      lap_start      = items_sent;
      while (items_sent - lap_start < 120) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          low_len = $urandom_range(1, tick_half);
          repeat (low_len) send_level(1'b0);
          repeat (tick_half - low_len + 2) send_level(1'b1);
        end else if (pick < 10) begin
          repeat ($urandom_range(1, 4)) send_level(1'($urandom_range(1)));
          repeat (10 * tick_full + start_len + 2) send_level(1'b1);
        end else begin
          pick = $urandom_range(99);
          ch   = (pick < 18) ? CH_CR : (pick < 23) ? CH_ZERO : 8'($urandom_range(255));
          send_byte(ch);
        end
      end
      if (line_fill != 0) send_byte(CH_CR);
    end

    drain_results();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("uart_line_echo_unit_tb: clean");
    end else begin
      $display("uart_line_echo_unit_tb: errors");
    end
    $finish;
  end

endmodule
